FILE: rtl/fsn_pkg.sv
`timescale 1ns / 1ps

package fsn_pkg;

	// Number of refinement iterations on the inverse square root estimate.
	localparam int unsigned N_STEPS = 2;

	localparam logic [31:0] SEED_MAGIC   = 32'h5f37_59df;
	localparam logic [31:0] HALF_ONE     = 32'h3f00_0000;
	localparam logic [31:0] THREE_HALVES = 32'h3fc0_0000;
	localparam logic [31:0] QNAN_DEFAULT = 32'hffc0_0000;
	localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
	localparam logic [7:0]  EXP_ALL_ONES = 8'hff;

	// Operands that ride along with an item while one operation is in flight.
	typedef struct packed {
		logic [31:0] value;
		logic [31:0] half;
		logic [31:0] est;
	} tag_t;

	// Leading zero count of a 28-bit word; 28 when the word is zero.
	function automatic logic [4:0] lzc28(input logic [27:0] x);
		logic [4:0] n;
		n = 5'd28;
		for (int i = 0; i < 28; i++) begin
			if (x[i]) begin
				n = 5'(27 - i);
			end
		end
		return n;
	endfunction

endpackage

FILE: rtl/fast_sqrt_newton.sv
`timescale 1ns / 1ps
// Approximate square root of a binary32 value by the inverse square root trick.
// Requests enter on the s_axis channel: s_axis_tdata holds the operand's bit
// pattern. Results leave on the m_axis channel: m_axis_tdata holds the root's
// bit pattern. One result comes out for every request, in request order.
// The datapath is a chain of pipelined floating point units: a three-stage
// multiplier for the halving, then per Newton step two multiplies, a
// four-stage subtract and a multiply, then the final multiply by the operand.
// The depth of the pipeline is set by that chain. Throughput is one request per
// cycle while the output is not stalled.
// The whole pipeline advances together: when a result waits at the output and
// the receiver holds m_axis_tready low, every stage holds and s_axis_tready
// drops, so nothing is lost or repeated. Bubbles move forward while the
// output register is empty. Reset clears every valid bit at once; the block
// accepts a request as soon as reset is released.
module fast_sqrt_newton (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value_bits
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [31:0] root_bits
);

	localparam int unsigned N = fsn_pkg::N_STEPS;

	logic          en;
	logic [31:0]   seed;
	fsn_pkg::tag_t in_tag;
	logic          half_vld;
	logic [31:0]   half_res;
	fsn_pkg::tag_t half_tag;

	logic          st_vld [0:N];
	fsn_pkg::tag_t st_tag [0:N];

	// The pipeline moves whenever the output register is free or being drained.
	assign en            = ~m_axis_tvalid | m_axis_tready;
	assign s_axis_tready = en;

	// Seed: magic constant minus the operand shifted right arithmetically.
	assign seed         = fsn_pkg::SEED_MAGIC - {s_axis_tdata[31], s_axis_tdata[31:1]};
	assign in_tag.value = s_axis_tdata;
	assign in_tag.half  = s_axis_tdata;
	assign in_tag.est   = seed;

	fsn_fmul u_half (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_axis_tvalid),
		.a       (s_axis_tdata),
		.b       (fsn_pkg::HALF_ONE),
		.in_tag  (in_tag),
		.vld     (half_vld),
		.res     (half_res),
		.out_tag (half_tag)
	);

	assign st_vld[0]       = half_vld;
	assign st_tag[0].value = half_tag.value;
	assign st_tag[0].half  = half_res;
	assign st_tag[0].est   = half_tag.est;

	// Each Newton step: est = est * (1.5 - (half * est) * est).
	for (genvar k = 0; k < N; k++) begin : g_step
		logic          v1, v2, v3, v4;
		logic [31:0]   t1, t2, t3, e4;
		fsn_pkg::tag_t tg1, tg2, tg3, tg4;

		fsn_fmul u_t1 (
			.clk (clk), .arst_n (arst_n), .en (en),
			.in_vld (st_vld[k]), .a (st_tag[k].half), .b (st_tag[k].est),
			.in_tag (st_tag[k]), .vld (v1), .res (t1), .out_tag (tg1)
		);

		fsn_fmul u_t2 (
			.clk (clk), .arst_n (arst_n), .en (en),
			.in_vld (v1), .a (t1), .b (tg1.est),
			.in_tag (tg1), .vld (v2), .res (t2), .out_tag (tg2)
		);

		fsn_fsub u_t3 (
			.clk (clk), .arst_n (arst_n), .en (en),
			.in_vld (v2), .a (fsn_pkg::THREE_HALVES), .b (t2),
			.in_tag (tg2), .vld (v3), .res (t3), .out_tag (tg3)
		);

		fsn_fmul u_est (
			.clk (clk), .arst_n (arst_n), .en (en),
			.in_vld (v3), .a (tg3.est), .b (t3),
			.in_tag (tg3), .vld (v4), .res (e4), .out_tag (tg4)
		);

		assign st_vld[k+1]       = v4;
		assign st_tag[k+1].value = tg4.value;
		assign st_tag[k+1].half  = tg4.half;
		assign st_tag[k+1].est   = e4;
	end

	// Root = value * (refined inverse square root); its output stage is the
	// block's output register.
	fsn_fmul u_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (st_vld[N]),
		.a       (st_tag[N].value),
		.b       (st_tag[N].est),
		.in_tag  (st_tag[N]),
		.vld     (m_axis_tvalid),
		.res     (m_axis_tdata),
		.out_tag ()
	);

endmodule

FILE: rtl/fsn_fmul.sv
`timescale 1ns / 1ps

// Three-stage binary32 multiplier, round to nearest even, full subnormal support.
module fsn_fmul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [31:0]        a,
	input  logic [31:0]        b,
	input  fsn_pkg::tag_t      in_tag,
	output logic               vld,
	output logic [31:0]        res,
	output fsn_pkg::tag_t      out_tag
);

	// Returns {mantissa[23:0], exponent[10:0]} with subnormals normalized.
	function automatic logic [34:0] unpack(input logic [31:0] x);
		logic [4:0]         lz;
		logic [23:0]        m;
		logic signed [10:0] e;
		lz = fsn_pkg::lzc28({1'b0, x[22:0], 4'b0});
		if (x[30:23] != 8'd0) begin
			m = {1'b1, x[22:0]};
			e = $signed({3'b0, x[30:23]});
		end else begin
			m = {1'b0, x[22:0]} << lz;
			e = 11'sd1 - $signed({6'b0, lz});
		end
		return {m, e};
	endfunction

	logic [34:0] ua, ub;
	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sgn;
	logic        spc;
	logic [31:0] spc_res;

	logic               vld_s1, vld_s2;
	logic               sgn_s1, sgn_s2;
	logic [23:0]        ma_s1, mb_s1;
	logic signed [10:0] ea_s1, eb_s1, e_s2;
	logic               spc_s1, spc_s2;
	logic [31:0]        spc_res_s1, spc_res_s2;
	fsn_pkg::tag_t      tag_s1, tag_s2;
	logic [47:0]        p_s2;

	always_comb begin
		ua     = unpack(a);
		ub     = unpack(b);
		sgn    = a[31] ^ b[31];
		nan_a  = (a[30:23] == fsn_pkg::EXP_ALL_ONES) && (a[22:0] != 23'd0);
		nan_b  = (b[30:23] == fsn_pkg::EXP_ALL_ONES) && (b[22:0] != 23'd0);
		inf_a  = (a[30:23] == fsn_pkg::EXP_ALL_ONES) && (a[22:0] == 23'd0);
		inf_b  = (b[30:23] == fsn_pkg::EXP_ALL_ONES) && (b[22:0] == 23'd0);
		zero_a = (a[30:0] == 31'd0);
		zero_b = (b[30:0] == 31'd0);
		spc    = 1'b1;
		if (nan_a) begin
			spc_res = a | fsn_pkg::QUIET_BIT;
		end else if (nan_b) begin
			spc_res = b | fsn_pkg::QUIET_BIT;
		end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
			spc_res = fsn_pkg::QNAN_DEFAULT;
		end else if (inf_a || inf_b) begin
			spc_res = {sgn, fsn_pkg::EXP_ALL_ONES, 23'd0};
		end else if (zero_a || zero_b) begin
			spc_res = {sgn, 31'd0};
		end else begin
			spc     = 1'b0;
			spc_res = {sgn, 31'd0};
		end
	end

	// Stage 3 datapath: normalize by one place, denormalize, round.
	logic               p47;
	logic [47:0]        m;
	logic signed [11:0] ex, dsh;
	logic [5:0]         sh;
	logic [47:0]        shifted;
	logic               lost, g, st, rup;
	logic [23:0]        kept;
	logic [7:0]         expf;
	logic [30:0]        r31;
	logic [31:0]        res_d;

	always_comb begin
		p47 = p_s2[47];
		m   = p47 ? p_s2 : (p_s2 << 1);
		ex  = p47 ? ($signed({e_s2[10], e_s2}) + 12'sd1) : $signed({e_s2[10], e_s2});
		dsh = 12'sd1 - ex;
		if (ex < 12'sd1) begin
			sh = (dsh > 12'sd63) ? 6'd63 : dsh[5:0];
		end else begin
			sh = 6'd0;
		end
		shifted = m >> sh;
		lost    = |(m & ~(48'hffff_ffff_ffff << sh));
		kept    = shifted[47:24];
		g       = shifted[23];
		st      = (|shifted[22:0]) | lost;
		rup     = g & (st | kept[0]);
		expf    = (ex < 12'sd1) ? 8'd0 : ex[7:0];
		r31     = {expf, kept[22:0]} + {30'd0, rup};
		if (spc_s2) begin
			res_d = spc_res_s2;
		end else if (ex >= 12'sd255) begin
			res_d = {sgn_s2, fsn_pkg::EXP_ALL_ONES, 23'd0};
		end else begin
			res_d = {sgn_s2, r31};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld    <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld    <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1     <= sgn;
			ma_s1      <= ua[34:11];
			mb_s1      <= ub[34:11];
			ea_s1      <= $signed(ua[10:0]);
			eb_s1      <= $signed(ub[10:0]);
			spc_s1     <= spc;
			spc_res_s1 <= spc_res;
			tag_s1     <= in_tag;

			sgn_s2     <= sgn_s1;
			p_s2       <= ma_s1 * mb_s1;
			e_s2       <= ea_s1 + eb_s1 - 11'sd127;
			spc_s2     <= spc_s1;
			spc_res_s2 <= spc_res_s1;
			tag_s2     <= tag_s1;

			res        <= res_d;
			out_tag    <= tag_s2;
		end
	end

endmodule

FILE: rtl/fsn_fsub.sv
`timescale 1ns / 1ps

// Four-stage binary32 subtractor a - b, round to nearest even.
module fsn_fsub (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [31:0]        a,
	input  logic [31:0]        b,
	input  fsn_pkg::tag_t      in_tag,
	output logic               vld,
	output logic [31:0]        res,
	output fsn_pkg::tag_t      out_tag
);

	// Stage 1: order by magnitude, detect specials.
	logic        sb, swap, eff_sub, zsgn, bsgn;
	logic [30:0] big, sml;
	logic [7:0]  eb, es, d;
	logic [23:0] mb, ms;
	logic        nan_a, nan_b, inf_a, inf_b, spc;
	logic [31:0] spc_res;

	always_comb begin
		sb      = ~b[31];
		swap    = b[30:0] > a[30:0];
		big     = swap ? b[30:0] : a[30:0];
		sml     = swap ? a[30:0] : b[30:0];
		bsgn    = swap ? sb : a[31];
		eff_sub = a[31] ^ sb;
		zsgn    = a[31] & sb;
		eb      = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es      = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		mb      = {big[30:23] != 8'd0, big[22:0]};
		ms      = {sml[30:23] != 8'd0, sml[22:0]};
		d       = eb - es;
		nan_a   = (a[30:23] == fsn_pkg::EXP_ALL_ONES) && (a[22:0] != 23'd0);
		nan_b   = (b[30:23] == fsn_pkg::EXP_ALL_ONES) && (b[22:0] != 23'd0);
		inf_a   = (a[30:23] == fsn_pkg::EXP_ALL_ONES) && (a[22:0] == 23'd0);
		inf_b   = (b[30:23] == fsn_pkg::EXP_ALL_ONES) && (b[22:0] == 23'd0);
		spc     = 1'b1;
		if (nan_a) begin
			spc_res = a | fsn_pkg::QUIET_BIT;
		end else if (nan_b) begin
			spc_res = b | fsn_pkg::QUIET_BIT;
		end else if (inf_a && inf_b && eff_sub) begin
			spc_res = fsn_pkg::QNAN_DEFAULT;
		end else if (inf_a) begin
			spc_res = a;
		end else if (inf_b) begin
			spc_res = {sb, fsn_pkg::EXP_ALL_ONES, 23'd0};
		end else begin
			spc     = 1'b0;
			spc_res = a;
		end
	end

	logic          vld_s1, vld_s2, vld_s3;
	logic          sgn_s1, sgn_s2, sgn_s3;
	logic          sub_s1, zsgn_s1, zsgn_s2;
	logic [7:0]    eb_s1, eb_s2, d_s1;
	logic [23:0]   mb_s1, ms_s1;
	logic          spc_s1, spc_s2, spc_s3;
	logic [31:0]   spc_res_s1, spc_res_s2, spc_res_s3;
	fsn_pkg::tag_t tag_s1, tag_s2, tag_s3;
	logic [27:0]   sum_s2;
	logic [26:0]   norm_s3;
	logic [8:0]    e_s3;

	// Stage 2: align the smaller operand and add or subtract.
	logic [26:0] mbx, msx, msh;
	logic        lost2;
	logic [27:0] sum;

	always_comb begin
		mbx   = {mb_s1, 3'b0};
		msh   = {ms_s1, 3'b0} >> d_s1;
		lost2 = |({ms_s1, 3'b0} & ~(27'h7ff_ffff << d_s1));
		if (d_s1 >= 8'd27) begin
			msx = {26'd0, |ms_s1};
		end else begin
			msx = {msh[26:1], msh[0] | lost2};
		end
		sum = sub_s1 ? ({1'b0, mbx} - {1'b0, msx}) : ({1'b0, mbx} + {1'b0, msx});
	end

	// Stage 3: normalize, bounded by the smallest normal exponent.
	logic [4:0]  lz;
	logic [7:0]  lim, shn;
	logic [26:0] norm;
	logic [8:0]  en3;
	logic        spc3;
	logic [31:0] spc_res3;

	always_comb begin
		lz  = fsn_pkg::lzc28(sum_s2);
		lim = eb_s2 - 8'd1;
		shn = ({3'b0, lz} - 8'd1 < lim) ? ({3'b0, lz} - 8'd1) : lim;
		if (sum_s2[27]) begin
			norm = {sum_s2[27:2], |sum_s2[1:0]};
			en3  = {1'b0, eb_s2} + 9'd1;
		end else begin
			norm = sum_s2[26:0] << shn;
			en3  = {1'b0, eb_s2} - {1'b0, shn};
		end
		spc3     = spc_s2 | (sum_s2 == 28'd0);
		spc_res3 = spc_s2 ? spc_res_s2 : {zsgn_s2, 31'd0};
	end

	// Stage 4: round and pack.
	logic [23:0] kept;
	logic        rup;
	logic [7:0]  expf;
	logic [30:0] r31;
	logic [31:0] res_d;

	always_comb begin
		kept = norm_s3[26:3];
		rup  = norm_s3[2] & (norm_s3[1] | norm_s3[0] | kept[0]);
		expf = norm_s3[26] ? e_s3[7:0] : 8'd0;
		r31  = {expf, kept[22:0]} + {30'd0, rup};
		if (spc_s3) begin
			res_d = spc_res_s3;
		end else if (e_s3 >= 9'd255) begin
			res_d = {sgn_s3, fsn_pkg::EXP_ALL_ONES, 23'd0};
		end else begin
			res_d = {sgn_s3, r31};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld    <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld    <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1     <= bsgn;
			sub_s1     <= eff_sub;
			zsgn_s1    <= zsgn;
			eb_s1      <= eb;
			d_s1       <= d;
			mb_s1      <= mb;
			ms_s1      <= ms;
			spc_s1     <= spc;
			spc_res_s1 <= spc_res;
			tag_s1     <= in_tag;

			sgn_s2     <= sgn_s1;
			zsgn_s2    <= zsgn_s1;
			eb_s2      <= eb_s1;
			sum_s2     <= sum;
			spc_s2     <= spc_s1;
			spc_res_s2 <= spc_res_s1;
			tag_s2     <= tag_s1;

			sgn_s3     <= sgn_s2;
			norm_s3    <= norm;
			e_s3       <= en3;
			spc_s3     <= spc3;
			spc_res_s3 <= spc_res3;
			tag_s3     <= tag_s2;

			res        <= res_d;
			out_tag    <= tag_s3;
		end
	end

endmodule
